@@ rtl/gf2_poly_divstep_engine_unit_macros.svh @@
// Assertion macros used by the top level of the divstep engine.
`ifndef GF2_POLY_DIVSTEP_ENGINE_UNIT_MACROS_SVH
`define GF2_POLY_DIVSTEP_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define GPDE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define GPDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gpde_pkg.sv @@
// Package with the shared constants and types of the divstep engine.
package gpde_pkg;

  localparam int FIELD_W       = 64;
  localparam int DELTA_W       = 10;
  localparam int STEP_W        = 8;
  localparam int MAX_STEPS     = 255;
  localparam int POLY_BITS_DEF = 64;
  localparam int NUM_POLY      = 6;

  localparam logic [STEP_W-1:0] STEP_COUNT_RST = 8'd125;

  // Slots of the polynomial bundle that travels down the pipeline.
  localparam int IDX_F = 0;
  localparam int IDX_G = 1;
  localparam int IDX_U = 2;
  localparam int IDX_V = 3;
  localparam int IDX_Q = 4;
  localparam int IDX_R = 5;

  // Control that travels with each word: its valid bit and its delta.
  typedef struct packed {
    logic               valid;
    logic [DELTA_W-1:0] delta;
  } gpde_ctrl_t;

endpackage

@@ rtl/gpde_load.sv @@
// Load stage: masks the operands, sets the initial delta and transition matrix.
module gpde_load #(
  parameter int POLY_BITS = gpde_pkg::POLY_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            valid_i,
  input  logic [gpde_pkg::FIELD_W-1:0]                    f_i,
  input  logic [gpde_pkg::FIELD_W-1:0]                    g_i,
  output gpde_pkg::gpde_ctrl_t                            ctrl_o,
  output logic [gpde_pkg::NUM_POLY-1:0][POLY_BITS-1:0]    polys_o
);
  import gpde_pkg::*;

  localparam int DEG_W = $clog2(POLY_BITS);

  gpde_ctrl_t                         ctrl_r, ctrl_nxt;
  logic [NUM_POLY-1:0][POLY_BITS-1:0] polys_r, polys_nxt;
  logic [POLY_BITS-1:0]               f_m, g_m;

  // Index of the highest set coefficient; the zero polynomial gives zero.
  function automatic logic [DEG_W-1:0] deg_of(input logic [POLY_BITS-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 0; i < POLY_BITS; i++) begin
      if (p[i]) d = DEG_W'(i);
    end
    return d;
  endfunction

  always_comb begin
    f_m = f_i[POLY_BITS-1:0];
    g_m = g_i[POLY_BITS-1:0];
    ctrl_nxt.valid = valid_i;
    ctrl_nxt.delta = DELTA_W'(deg_of(f_m)) - DELTA_W'(deg_of(g_m));
    polys_nxt        = '0;
    polys_nxt[IDX_F] = f_m;
    polys_nxt[IDX_G] = g_m;
    polys_nxt[IDX_U] = POLY_BITS'(1);
    polys_nxt[IDX_R] = POLY_BITS'(1);
  end

  // Only the valid bit is reset; the payload simply follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else if (en) begin
      ctrl_r.valid <= ctrl_nxt.valid;
    end
    if (en) begin
      ctrl_r.delta <= ctrl_nxt.delta;
      polys_r      <= polys_nxt;
    end
  end

  assign ctrl_o  = ctrl_r;
  assign polys_o = polys_r;

endmodule

@@ rtl/gpde_divstep.sv @@
// One registered divstep stage; it passes the word through when its step is not run.
module gpde_divstep #(
  parameter int POLY_BITS = gpde_pkg::POLY_BITS_DEF,
  parameter int STEP_IDX  = 0
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic [gpde_pkg::STEP_W-1:0]                     step_count,
  input  gpde_pkg::gpde_ctrl_t                            ctrl_i,
  input  logic [gpde_pkg::NUM_POLY-1:0][POLY_BITS-1:0]    polys_i,
  output gpde_pkg::gpde_ctrl_t                            ctrl_o,
  output logic [gpde_pkg::NUM_POLY-1:0][POLY_BITS-1:0]    polys_o
);
  import gpde_pkg::*;

  localparam logic [STEP_W-1:0] StepIdxC = STEP_W'(STEP_IDX);

  gpde_ctrl_t                         ctrl_r, ctrl_nxt;
  logic [NUM_POLY-1:0][POLY_BITS-1:0] polys_r, polys_nxt;
  logic                               active, swap, f0, g0;
  logic [DELTA_W-1:0]                 delta_sw;
  logic [POLY_BITS-1:0]               f1, g1, u1, v1, q1, r1;

  always_comb begin
    active = ctrl_i.valid && (StepIdxC < step_count);
    swap   = active && (ctrl_i.delta != '0) && !ctrl_i.delta[DELTA_W-1]
             && polys_i[IDX_G][0];

    f1 = swap ? polys_i[IDX_G] : polys_i[IDX_F];
    g1 = swap ? polys_i[IDX_F] : polys_i[IDX_G];
    u1 = swap ? polys_i[IDX_Q] : polys_i[IDX_U];
    q1 = swap ? polys_i[IDX_U] : polys_i[IDX_Q];
    v1 = swap ? polys_i[IDX_R] : polys_i[IDX_V];
    r1 = swap ? polys_i[IDX_V] : polys_i[IDX_R];
    delta_sw = swap ? (~ctrl_i.delta + DELTA_W'(1)) : ctrl_i.delta;

    f0 = f1[0];
    g0 = g1[0];

    ctrl_nxt.valid = ctrl_i.valid;
    polys_nxt      = polys_i;
    ctrl_nxt.delta = ctrl_i.delta;
    if (active) begin
      ctrl_nxt.delta   = delta_sw + DELTA_W'(1);
      polys_nxt[IDX_F] = f1;
      polys_nxt[IDX_G] = ((f0 ? g1 : '0) ^ (g0 ? f1 : '0)) >> 1;
      polys_nxt[IDX_Q] = (f0 ? q1 : '0) ^ (g0 ? u1 : '0);
      polys_nxt[IDX_R] = (f0 ? r1 : '0) ^ (g0 ? v1 : '0);
      polys_nxt[IDX_U] = u1 << 1;
      polys_nxt[IDX_V] = v1 << 1;
    end
  end

  // Only the valid bit is reset; the payload simply follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else if (en) begin
      ctrl_r.valid <= ctrl_nxt.valid;
    end
    if (en) begin
      ctrl_r.delta <= ctrl_nxt.delta;
      polys_r      <= polys_nxt;
    end
  end

  assign ctrl_o  = ctrl_r;
  assign polys_o = polys_r;

endmodule

@@ rtl/gf2_poly_divstep_engine_unit.sv @@
// Top level of the GF(2) polynomial divstep engine: load, divstep chain, output register.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall   | in_f_in, in_g_in
//   out     | output    | out_valid/out_stall | out_delta_out, f, g, u, v, q, r
//   cfg     | input     | cfg_we              | cfg_wdata (step_count)
//
// Every word passes through the same 257 register stages: one load stage, MAX_STEPS
// divstep stages and the output register. One word enters and one leaves per cycle
// while the output is not stalled; the chain of one divstep per stage sets this.
// Reset is synchronous and active low; it clears all valid bits, sets step_count to 125
// and holds in_stall high. A stalled output word freezes the whole pipeline, so in_stall
// follows out_stall whenever the output register holds a word; nothing is dropped.
`include "gf2_poly_divstep_engine_unit_macros.svh"

module gf2_poly_divstep_engine_unit #(
  parameter int POLY_BITS = gpde_pkg::POLY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gpde_pkg::FIELD_W-1:0]         in_f_in,
  input  logic [gpde_pkg::FIELD_W-1:0]         in_g_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gpde_pkg::DELTA_W-1:0]  out_delta_out,
  output logic [gpde_pkg::FIELD_W-1:0]         out_f_out,
  output logic [gpde_pkg::FIELD_W-1:0]         out_g_out,
  output logic [gpde_pkg::FIELD_W-1:0]         out_u_out,
  output logic [gpde_pkg::FIELD_W-1:0]         out_v_out,
  output logic [gpde_pkg::FIELD_W-1:0]         out_q_out,
  output logic [gpde_pkg::FIELD_W-1:0]         out_r_out,
  input  logic                                 cfg_we,
  input  logic [gpde_pkg::STEP_W-1:0]          cfg_wdata
);
  import gpde_pkg::*;

  // Bound on the final delta: the initial degree gap plus one per divstep.
  localparam int DeltaBound = POLY_BITS + MAX_STEPS;

  logic                               en;
  logic [STEP_W-1:0]                  step_count_r;
  gpde_ctrl_t                         ctrl_chain  [MAX_STEPS+1];
  logic [NUM_POLY-1:0][POLY_BITS-1:0] polys_chain [MAX_STEPS+1];

  logic                               out_valid_r;
  logic [DELTA_W-1:0]                 out_delta_r;
  logic [NUM_POLY-1:0][POLY_BITS-1:0] out_polys_r;

  // The pipeline moves whenever the output register is empty or being drained.
  // No word is taken while reset is applied, since the load stage clears it.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en || !rst_n;

  // The user must write step_count only while the engine is idle; it is not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEP_COUNT_RST;
    end else if (cfg_we) begin
      step_count_r <= cfg_wdata;
    end
  end

  gpde_load #(
    .POLY_BITS (POLY_BITS)
  ) u_load (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .f_i     (in_f_in),
    .g_i     (in_g_in),
    .ctrl_o  (ctrl_chain[0]),
    .polys_o (polys_chain[0])
  );

  // Stage k runs divstep k when k is below step_count and passes the word on otherwise,
  // which keeps the latency the same for every step count.
  for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
    gpde_divstep #(
      .POLY_BITS (POLY_BITS),
      .STEP_IDX  (k)
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .step_count (step_count_r),
      .ctrl_i     (ctrl_chain[k]),
      .polys_i    (polys_chain[k]),
      .ctrl_o     (ctrl_chain[k+1]),
      .polys_o    (polys_chain[k+1])
    );
  end

  // Output register: holds the finished word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctrl_chain[MAX_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_delta_r <= ctrl_chain[MAX_STEPS].delta;
      out_polys_r <= polys_chain[MAX_STEPS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_delta_out = out_delta_r;
  assign out_f_out     = FIELD_W'(out_polys_r[IDX_F]);
  assign out_g_out     = FIELD_W'(out_polys_r[IDX_G]);
  assign out_u_out     = FIELD_W'(out_polys_r[IDX_U]);
  assign out_v_out     = FIELD_W'(out_polys_r[IDX_V]);
  assign out_q_out     = FIELD_W'(out_polys_r[IDX_Q]);
  assign out_r_out     = FIELD_W'(out_polys_r[IDX_R]);

  // An accepted input word must show up as valid in the load stage.
  `GPDE_ASSERT_NEXT(a_load_takes_word, clk, rst_n, in_valid && !in_stall, ctrl_chain[0].valid, "accepted word missing from load stage")

  // A held output word must freeze the last divstep stage as well.
  `GPDE_ASSERT_NEXT(a_chain_frozen, clk, rst_n, out_valid && out_stall, $stable(ctrl_chain[MAX_STEPS]), "divstep chain moved while output stalled")

  // The final delta can never leave the range set by degree gap and step count.
  `GPDE_ASSERT_IMPL(a_delta_range, clk, rst_n, out_valid, (int'(out_delta_out) <= DeltaBound) && (int'(out_delta_out) >= -DeltaBound), "final delta out of range")

endmodule
